FILE: hdl/eaec_pkg.sv
// shared types, widths and fixed-point coefficients for the eta/angle energy correction
package eaec_pkg;

    localparam int EW  = 20;          // energy, target peak and quotient width
    localparam int HW  = 17;          // eta width
    localparam int TW  = 15;          // angle width
    localparam int PW  = 2 * EW;      // energy times target peak
    localparam int CW  = 35;          // signed q.24 intercept / slope
    localparam int AW  = 52;          // signed accumulator width
    localparam int FW  = 28;          // signed q.16 expected peak
    localparam int NW  = PW + 10;     // dividend width

    localparam logic [EW-1:0] EN_MAX = {EW{1'b1}};

    // signed q.24 coefficients
    localparam logic signed [31:0] K_AL0 = 32'sd937797982;
    localparam logic signed [31:0] K_AL1 = -32'sd20084843;
    localparam logic signed [31:0] K_AL2 = 32'sd421833;
    localparam logic signed [31:0] K_BL0 = -32'sd717302720;
    localparam logic signed [31:0] K_BL1 = 32'sd42826353;
    localparam logic signed [31:0] K_BL2 = -32'sd668943;
    localparam logic signed [31:0] K_AR0 = -32'sd441420296;
    localparam logic signed [31:0] K_AR1 = 32'sd28680304;
    localparam logic signed [31:0] K_BR0 = 32'sd1553137738;
    localparam logic signed [31:0] K_BR1 = -32'sd36330612;

    typedef logic signed [CW-1:0] t_q24;

    typedef struct packed {
        logic [EW-1:0] energy;
        logic [HW-1:0] eta;
        logic [TW-1:0] angle;
        logic [EW-1:0] peak;
    } t_item;

    typedef struct packed {
        t_q24          cl;
        t_q24          sl;
        t_q24          cr;
        t_q24          sr;
        logic [HW-1:0] eta;
        logic [PW-1:0] ep;
    } t_lines;

    typedef struct packed {
        logic [NW-1:0] n;
        logic [FW-1:0] d;
        logic          inv;
    } t_div_in;

    typedef struct packed {
        logic [EW-1:0] energy;
        logic          inv;
        logic          sat;
    } t_result;

endpackage

FILE: hdl/eta_angle_energy_correction.sv
// top level: eta and track-angle energy correction with stream ports and output skid
// from input transfer to the earliest output transfer: 6 arithmetic stages,
//   1 range-check stage, 20 divider stages, 1 output register
// throughput: one item per cycle unless stalled; the 20-stage divider sets the depth
// a stalled output is backed by a one-entry skid register, so one more item is taken
// reset: synchronous active-low, clears valid bits and target_peak (to 0)
module eta_angle_energy_correction (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_wdata,       // target_peak
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,    // energy_in, eta_ratio, track_angle, zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,    // energy_out, zero pad
    output logic [1:0]  o_m_axis_tuser     // invalid, saturated
);
    import eaec_pkg::*;

    logic [EW-1:0] r_target_peak;
    logic          r_ov, r_sv;
    t_result       r_od, r_sd;

    logic          n_en;
    logic          n_take;
    logic          n_arrive;
    t_item         n_item;
    logic          n_lines_v, n_div_v, n_res_v;
    t_lines        n_lines;
    t_div_in       n_div;
    t_result       n_res;

    assign n_en            = ~r_sv;
    assign o_s_axis_tready = n_en;
    assign n_take          = r_ov & i_m_axis_tready;
    assign n_arrive        = n_en & n_res_v;

    always_comb begin
        n_item.energy = i_s_axis_tdata[EW-1:0];
        n_item.eta    = i_s_axis_tdata[EW+HW-1:EW];
        n_item.angle  = i_s_axis_tdata[EW+HW+TW-1:EW+HW];
        n_item.peak   = r_target_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_peak <= '0;
        end else if (i_cfg_we) begin
            r_target_peak <= i_cfg_wdata;
        end
    end

    eaec_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (i_s_axis_tvalid),
        .i_data  (n_item),
        .o_valid (n_lines_v),
        .o_data  (n_lines)
    );

    eaec_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (n_lines_v),
        .i_data  (n_lines),
        .o_valid (n_div_v),
        .o_data  (n_div)
    );

    eaec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (n_div_v),
        .i_data  (n_div),
        .o_valid (n_res_v),
        .o_data  (n_res)
    );

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (n_take) begin
                r_sv <= 1'b0;
            end
        end else if (n_arrive) begin
            if (!r_ov || n_take) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (n_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (n_take) begin
                r_od <= r_sd;
            end
        end else if (n_arrive) begin
            if (!r_ov || n_take) begin
                r_od <= n_res;
            end else begin
                r_sd <= n_res;
            end
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {{(24-EW){1'b0}}, r_od.energy};
    assign o_m_axis_tuser  = {r_od.sat, r_od.inv};

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry held without a pending output");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("invalid and saturated both set");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("invalid result with non-zero energy");

endmodule

FILE: hdl/eaec_coef.sv
// angle polynomials: intercepts and slopes of both eta lines, three stages
module eaec_coef (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  eaec_pkg::t_item  i_data,
    output logic             o_valid,
    output eaec_pkg::t_lines o_data
);
    import eaec_pkg::*;

    localparam logic signed [AW-1:0] RND16 = AW'(64'sd32768);

    function automatic t_q24 rnd_poly(
        input logic signed [31:0]   c0,
        input logic signed [47:0]   c1t,
        input logic signed [AW-1:0] c2tt
    );
        logic signed [AW-1:0] acc;
        acc = (AW'(c0) <<< 16) + (AW'(c1t) <<< 8) + c2tt + RND16;
        return acc[CW+15:16];
    endfunction

    // stage 1
    logic                   r1_v;
    logic [2*TW-1:0]        r1_tt;
    logic signed [47:0]     r1_al1t, r1_bl1t, r1_ar1t, r1_br1t;
    logic [HW-1:0]          r1_eta;
    logic [PW-1:0]          r1_ep;
    // stage 2
    logic                   r2_v;
    logic signed [AW-1:0]   r2_al2tt, r2_bl2tt;
    logic signed [47:0]     r2_al1t, r2_bl1t, r2_ar1t, r2_br1t;
    logic [HW-1:0]          r2_eta;
    logic [PW-1:0]          r2_ep;
    // stage 3
    logic                   r3_v;
    t_lines                 r3_data;

    logic signed [TW:0]     n_ts;
    logic signed [2*TW:0]   n_tts;
    t_lines                 n_lines;

    assign n_ts  = $signed({1'b0, i_data.angle});
    assign n_tts = $signed({1'b0, r1_tt});

    always_comb begin
        n_lines.cl  = rnd_poly(K_AL0, r2_al1t, r2_al2tt);
        n_lines.sl  = rnd_poly(K_BL0, r2_bl1t, r2_bl2tt);
        n_lines.cr  = rnd_poly(K_AR0, r2_ar1t, '0);
        n_lines.sr  = rnd_poly(K_BR0, r2_br1t, '0);
        n_lines.eta = r2_eta;
        n_lines.ep  = r2_ep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_tt    <= (2*TW)'(i_data.angle) * (2*TW)'(i_data.angle);
            r1_al1t  <= 48'(K_AL1) * 48'(n_ts);
            r1_bl1t  <= 48'(K_BL1) * 48'(n_ts);
            r1_ar1t  <= 48'(K_AR1) * 48'(n_ts);
            r1_br1t  <= 48'(K_BR1) * 48'(n_ts);
            r1_eta   <= i_data.eta;
            r1_ep    <= PW'(i_data.energy) * PW'(i_data.peak);

            r2_al2tt <= AW'(K_AL2) * AW'(n_tts);
            r2_bl2tt <= AW'(K_BL2) * AW'(n_tts);
            r2_al1t  <= r1_al1t;
            r2_bl1t  <= r1_bl1t;
            r2_ar1t  <= r1_ar1t;
            r2_br1t  <= r1_br1t;
            r2_eta   <= r1_eta;
            r2_ep    <= r1_ep;

            r3_data  <= n_lines;
        end
    end

    assign o_valid = r3_v;
    assign o_data  = r3_data;

endmodule

FILE: hdl/eaec_line.sv
// both eta lines, their maximum and the dividend and divisor, three stages
module eaec_line (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  eaec_pkg::t_lines  i_data,
    output logic              o_valid,
    output eaec_pkg::t_div_in o_data
);
    import eaec_pkg::*;

    localparam logic signed [AW-1:0] RND24 = AW'(64'sd8388608);

    // stage 4
    logic                 r4_v;
    logic signed [AW-1:0] r4_slh, r4_srh;
    t_q24                 r4_cl, r4_cr;
    logic [PW-1:0]        r4_ep;
    // stage 5
    logic                 r5_v;
    logic signed [FW-1:0] r5_fl, r5_fr;
    logic [PW-1:0]        r5_ep;
    // stage 6
    logic                 r6_v;
    t_div_in              r6_data;

    logic signed [HW:0]   n_hs;
    logic signed [AW-1:0] n_accl, n_accr;
    logic signed [FW-1:0] n_f;
    logic [FW-2:0]        n_fpos;
    t_div_in              n_div;

    assign n_hs   = $signed({1'b0, i_data.eta});
    assign n_accl = (AW'(r4_cl) <<< 16) + r4_slh + RND24;
    assign n_accr = (AW'(r4_cr) <<< 16) + r4_srh + RND24;

    always_comb begin
        n_f       = (r5_fl > r5_fr) ? r5_fl : r5_fr;
        n_fpos    = n_f[FW-2:0];
        n_div.inv = n_f[FW-1] | (n_f == '0);
        n_div.d   = {n_fpos, 1'b0};
        n_div.n   = {1'b0, r5_ep, 9'b0} + NW'(n_fpos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= i_valid;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_slh  <= AW'(i_data.sl) * AW'(n_hs);
            r4_srh  <= AW'(i_data.sr) * AW'(n_hs);
            r4_cl   <= i_data.cl;
            r4_cr   <= i_data.cr;
            r4_ep   <= i_data.ep;

            r5_fl   <= n_accl[FW+23:24];
            r5_fr   <= n_accr[FW+23:24];
            r5_ep   <= r4_ep;

            r6_data <= n_div;
        end
    end

    assign o_valid = r6_v;
    assign o_data  = r6_data;

endmodule

FILE: hdl/eaec_div.sv
// range check and restoring divider, one quotient bit per stage
module eaec_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  eaec_pkg::t_div_in i_data,
    output logic              o_valid,
    output eaec_pkg::t_result o_data
);
    import eaec_pkg::*;

    localparam int HIW = NW - EW;

    typedef struct packed {
        logic [FW-1:0] rem;
        logic [EW-1:0] lo;
        logic [EW-1:0] q;
        logic [FW-1:0] d;
        logic          ovf;
        logic          inv;
    } t_dstep;

    // one restoring step: shift in the next dividend bit, subtract when it fits
    function automatic t_dstep div_step(input t_dstep s);
        logic [FW:0] trial;
        logic        ge;
        t_dstep      nxt;
        trial   = {s.rem, s.lo[EW-1]};
        ge      = trial >= {1'b0, s.d};
        nxt     = s;
        nxt.rem = ge ? FW'(trial - {1'b0, s.d}) : trial[FW-1:0];
        nxt.lo  = {s.lo[EW-2:0], 1'b0};
        nxt.q   = {s.q[EW-2:0], ge};
        return nxt;
    endfunction

    logic [EW:0] r_v;
    t_dstep      r_st [0:EW];
    t_dstep      n_st0;

    always_comb begin
        n_st0.rem = i_data.n[EW+FW-1:EW];
        n_st0.lo  = i_data.n[EW-1:0];
        n_st0.q   = '0;
        n_st0.d   = i_data.d;
        n_st0.ovf = i_data.n[NW-1:EW] >= HIW'(i_data.d);
        n_st0.inv = i_data.inv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[EW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
            for (int k = 0; k < EW; k++) begin
                r_st[k+1] <= div_step(r_st[k]);
            end
        end
    end

    always_comb begin
        o_data.inv = r_st[EW].inv;
        o_data.sat = ~r_st[EW].inv & r_st[EW].ovf;
        if (r_st[EW].inv) begin
            o_data.energy = '0;
        end else if (r_st[EW].ovf) begin
            o_data.energy = EN_MAX;
        end else begin
            o_data.energy = r_st[EW].q;
        end
    end

    assign o_valid = r_v[EW];

endmodule
